// ===== hw/rtl/mwbm_pkg.sv =====
// ----------------------------------------------------------------------------
// Wall belief map package
// Types, codes and geometry helpers shared by the map store and the top level.
// ----------------------------------------------------------------------------
package mwbm_pkg;

    localparam int GRID_SIZE = 16;
    localparam logic [4:0] GRID_N = 5'(GRID_SIZE);

    typedef enum logic [1:0] {
        OP_QUERY  = 2'd0,
        OP_SET    = 2'd1,
        OP_REINIT = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        SIDE_NORTH = 2'd0,
        SIDE_EAST  = 2'd1,
        SIDE_SOUTH = 2'd2,
        SIDE_WEST  = 2'd3
    } side_t;

    typedef struct packed {
        logic       wall_present;
        logic [1:0] side;
        logic [3:0] cell_col;
        logic [3:0] cell_row;
        logic [1:0] op;
    } req_t;

    typedef struct packed {
        logic side_known;
        logic wall_pessimistic;
        logic wall_optimistic;
    } res_t;

    function automatic logic in_grid(input logic [3:0] row, input logic [3:0] col);
        return ({1'b0, row} < GRID_N) && ({1'b0, col} < GRID_N);
    endfunction

    function automatic logic boundary_bit(input logic [1:0] side, input logic [3:0] row,
                                          input logic [3:0] col);
        logic b;
        b = 1'b0;
        case (side)
            SIDE_NORTH: b = ({1'b0, row} == GRID_N - 5'd1);
            SIDE_EAST:  b = ({1'b0, col} == GRID_N - 5'd1);
            SIDE_SOUTH: b = (row == 4'd0);
            SIDE_WEST:  b = (col == 4'd0);
            default:    b = 1'b0;
        endcase
        return b && in_grid(row, col);
    endfunction

endpackage

// ===== hw/rtl/mwbm_grid.sv =====
// ----------------------------------------------------------------------------
// Wall belief map store
// Holds wall and known bits per cell side, applies set and reinitialize
// requests with neighbor mirroring, and reports the addressed side.
// ----------------------------------------------------------------------------
module mwbm_grid (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           upd,
    input  mwbm_pkg::req_t req,
    output mwbm_pkg::res_t res
);

    logic [15:0] wall_reg   [4][16];
    logic [15:0] known_reg  [4][16];
    logic [15:0] wall_next  [4][16];
    logic [15:0] known_next [4][16];
    logic        in_range;
    logic        rd_wall;
    logic        rd_known;
    logic [3:0]  row_up;
    logic [3:0]  row_dn;
    logic [3:0]  col_up;
    logic [3:0]  col_dn;

    assign in_range = mwbm_pkg::in_grid(req.cell_row, req.cell_col);
    assign row_up = req.cell_row + 4'd1;
    assign row_dn = req.cell_row - 4'd1;
    assign col_up = req.cell_col + 4'd1;
    assign col_dn = req.cell_col - 4'd1;

    always_comb begin
        wall_next  = wall_reg;
        known_next = known_reg;
        if (req.op == mwbm_pkg::OP_REINIT) begin
            for (int s = 0; s < 4; s++) begin
                for (int r = 0; r < 16; r++) begin
                    for (int c = 0; c < 16; c++) begin
                        wall_next[s][r][c]  = mwbm_pkg::boundary_bit(2'(s), 4'(r), 4'(c));
                        known_next[s][r][c] = mwbm_pkg::boundary_bit(2'(s), 4'(r), 4'(c));
                    end
                end
            end
        end else if (req.op == mwbm_pkg::OP_SET && in_range) begin
            wall_next[req.side][req.cell_row][req.cell_col]  = req.wall_present;
            known_next[req.side][req.cell_row][req.cell_col] = 1'b1;
            case (req.side)
                mwbm_pkg::SIDE_NORTH: begin
                    if ({1'b0, req.cell_row} + 5'd1 < mwbm_pkg::GRID_N) begin
                        wall_next[mwbm_pkg::SIDE_SOUTH][row_up][req.cell_col]  = req.wall_present;
                        known_next[mwbm_pkg::SIDE_SOUTH][row_up][req.cell_col] = 1'b1;
                    end
                end
                mwbm_pkg::SIDE_SOUTH: begin
                    if (req.cell_row != 4'd0) begin
                        wall_next[mwbm_pkg::SIDE_NORTH][row_dn][req.cell_col]  = req.wall_present;
                        known_next[mwbm_pkg::SIDE_NORTH][row_dn][req.cell_col] = 1'b1;
                    end
                end
                mwbm_pkg::SIDE_EAST: begin
                    if ({1'b0, req.cell_col} + 5'd1 < mwbm_pkg::GRID_N) begin
                        wall_next[mwbm_pkg::SIDE_WEST][req.cell_row][col_up]  = req.wall_present;
                        known_next[mwbm_pkg::SIDE_WEST][req.cell_row][col_up] = 1'b1;
                    end
                end
                default: begin
                    if (req.cell_col != 4'd0) begin
                        wall_next[mwbm_pkg::SIDE_EAST][req.cell_row][col_dn]  = req.wall_present;
                        known_next[mwbm_pkg::SIDE_EAST][req.cell_row][col_dn] = 1'b1;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int s = 0; s < 4; s++) begin
                for (int r = 0; r < 16; r++) begin
                    for (int c = 0; c < 16; c++) begin
                        wall_reg[s][r][c]  <= mwbm_pkg::boundary_bit(2'(s), 4'(r), 4'(c));
                        known_reg[s][r][c] <= mwbm_pkg::boundary_bit(2'(s), 4'(r), 4'(c));
                    end
                end
            end
        end else if (upd) begin
            wall_reg  <= wall_next;
            known_reg <= known_next;
        end
    end

    always_comb begin
        rd_wall  = wall_reg[req.side][req.cell_row][req.cell_col];
        rd_known = known_reg[req.side][req.cell_row][req.cell_col];
        case (req.op)
            mwbm_pkg::OP_SET: begin
                rd_wall  = req.wall_present;
                rd_known = 1'b1;
            end
            mwbm_pkg::OP_REINIT: begin
                rd_wall  = mwbm_pkg::boundary_bit(req.side, req.cell_row, req.cell_col);
                rd_known = rd_wall;
            end
            default: begin
            end
        endcase
        if (!in_range) begin
            res.wall_optimistic  = 1'b1;
            res.wall_pessimistic = 1'b1;
            res.side_known       = 1'b0;
        end else begin
            res.wall_optimistic  = rd_wall;
            res.wall_pessimistic = rd_wall | ~rd_known;
            res.side_known       = rd_known;
        end
    end

endmodule

// ===== hw/rtl/maze_wall_belief_map.sv =====
// ----------------------------------------------------------------------------
// Maze wall belief map
// Per-side wall and known map of a square grid with query, set and
// reinitialize requests; one three-bit result per request.
// ----------------------------------------------------------------------------
// Usage:
//   Send requests on the s_ stream: op, cell_row, cell_col, side and
//   wall_present packed into s_tdata. Each request returns exactly one
//   result on the m_ stream: optimistic wall, pessimistic wall and known
//   for the addressed side as it stands after the request.
//   A request accepted on s_ is registered in the input register; when
//   it advances it is applied to the map and its result is registered in
//   the output register, which drives m_tvalid until the result is taken.
//   Throughput is one request per cycle while m_tready is high: the map is in
//   flip-flops; a set writes two side bits at most, a reinit all, in one cycle.
//   Reset (aresetn low, synchronous) empties both stages and loads the map
//   with only the outer boundary walls set and known.
//   When the receiver stalls, the result is held in the output register and
//   one more request is held in the input register; s_tready then drops.
// ----------------------------------------------------------------------------
module maze_wall_belief_map (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [1:0] op, [5:2] cell_row, [9:6] cell_col, [11:10] side,
    // [12] wall_present, [15:13] zero
    input  logic [15:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] wall_optimistic, [1] wall_pessimistic, [2] side_known, [7:3] zero
    output logic [7:0]  m_tdata
);

    logic           in_valid_reg;
    logic           in_valid_next;
    mwbm_pkg::req_t in_req_reg;
    logic           out_valid_reg;
    logic           out_valid_next;
    mwbm_pkg::res_t out_res_reg;
    mwbm_pkg::res_t res;
    logic           advance;
    logic           take;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign take     = s_tvalid && s_tready;

    assign in_valid_next  = take || (in_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && !m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            in_req_reg <= mwbm_pkg::req_t'(s_tdata[12:0]);
        end
        if (advance) begin
            out_res_reg <= res;
        end
    end

    mwbm_grid u_grid (
        .aclk    (aclk),
        .aresetn (aresetn),
        .upd     (advance),
        .req     (in_req_reg),
        .res     (res)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_res_reg};

    a_unknown_is_pessimistic: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[2] || m_tdata[1]))
        else $error("unknown side not reported as pessimistic wall");

    a_wall_is_pessimistic: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (!m_tdata[0] || m_tdata[1]))
        else $error("optimistic wall without pessimistic wall");

    a_set_marks_known: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_req_reg.op == mwbm_pkg::OP_SET
         && mwbm_pkg::in_grid(in_req_reg.cell_row, in_req_reg.cell_col))
        |=> (out_valid_reg && out_res_reg.side_known
             && out_res_reg.wall_optimistic == $past(in_req_reg.wall_present)))
        else $error("set request result does not reflect the write");

    a_request_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(in_req_reg)))
        else $error("pending request lost from input register");

endmodule
